FILE: rtl/core/cfm_pkg.sv
package cfm_pkg;

  // Width of the timer input and of the counters kept between captures.
  localparam int CAPTURE_BITS       = 16;
  localparam int TIMER_BITS_DEFAULT = 16;

  // Gate length after reset: two seconds of a 16 MHz clock.
  localparam logic [31:0] GATE_RESET = 32'd32000000;

  // Shared divider: a 33-bit numerator over a 32-bit divisor.
  localparam int DIV_NUM_BITS = 33;
  localparam int DIV_DEN_BITS = 32;
  localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS + 1);

  // Frequency scale factors (16 MHz clock, result times 100) and the
  // period thresholds that pick among them.
  localparam logic [30:0] SCALE_MHZ = 31'd1600;
  localparam logic [30:0] SCALE_KHZ = 31'd1600000;
  localparam logic [30:0] SCALE_HZ  = 31'd1600000000;
  localparam logic [31:0] LIMIT_MHZ = 32'd16;
  localparam logic [31:0] LIMIT_KHZ = 32'd16000;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_CAPTURE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    UNIT_MHZ = 2'd0,
    UNIT_KHZ = 2'd1,
    UNIT_HZ  = 2'd2
  } unit_t;

endpackage

FILE: rtl/core/cfm_if.sv
// Request channel carrying timer events into the meter.
interface cfm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] capture_value;
  logic        capture_overrun;

  modport source (output valid, output command, output capture_value,
                  output capture_overrun, input ready);
  modport sink   (input valid, input command, input capture_value,
                  input capture_overrun, output ready);
endinterface

// Request channel carrying one finished measurement out of the meter.
interface cfm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] average_period;
  logic [16:0] frequency_x100;
  logic [1:0]  unit;
  logic        zero_period;

  modport source (output valid, output average_period, output frequency_x100,
                  output unit, output zero_period, input ready);
  modport sink   (input valid, input average_period, input frequency_x100,
                  input unit, input zero_period, output ready);
endinterface

FILE: rtl/core/cfm_div.sv
// Restoring divider, one quotient bit per cycle. A zero divisor yields zero.
module cfm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cfm_pkg::DIV_NUM_BITS-1:0]  num,
  input  logic [cfm_pkg::DIV_DEN_BITS-1:0]  den,
  output logic                              done,
  output logic [cfm_pkg::DIV_NUM_BITS-1:0]  quot
);

  localparam int NB = cfm_pkg::DIV_NUM_BITS;
  localparam int DB = cfm_pkg::DIV_DEN_BITS;
  localparam int CB = cfm_pkg::DIV_CNT_BITS;

  logic          busy;
  logic [CB-1:0] cnt;
  logic [DB-1:0] rem;
  logic [NB-1:0] quo;
  logic [DB-1:0] den_r;
  logic          den_zero;

  logic [DB:0]   rem_sh;
  logic          ge;
  logic [DB:0]   diff;
  logic [DB-1:0] rem_next;
  logic [NB-1:0] quo_next;

  always_comb begin
    rem_sh   = {rem, quo[NB-1]};
    ge       = rem_sh >= {1'b0, den_r};
    diff     = rem_sh - {1'b0, den_r};
    rem_next = ge ? diff[DB-1:0] : rem_sh[DB-1:0];
    quo_next = {quo[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quo      <= num;
      den_r    <= den;
      den_zero <= (den == '0);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quot = den_zero ? '0 : quo;

endmodule

FILE: rtl/core/capture_frequency_meter.sv
// Reciprocal frequency meter over a free-running timer clocked at 16 MHz.
// Requests arrive on the item channel (valid/ready): a start command clears
// the counters and arms the meter, overflow ticks count timer wraps, and
// edge captures carry the latched timer value and an overrun flag. Ticks,
// starts and captures that do not end the gate leave the meter in S_ACCUM
// with item.ready high, so it can take the next request straight away.
// The capture that brings the cycle sum to at least gate_cycles starts two
// passes through one shared bit-serial divider: first the rounded average
// period, then the rounded frequency. The meter then steps through the
// states S_AVG_GO, S_AVG_WAIT, S_FRQ_GO, S_FRQ_WAIT and S_EMIT, and
// item.ready stays low until the result is loaded into the output register.
// A held result does not block new items; only a second finished result
// waits for the first to be taken. The user writes gate_cycles through
// cfg_we/cfg_wdata only while the meter is idle; this is not enforced.
// Reset clears the meter to idle (disarmed), empties the output register
// and sets gate_cycles to 32000000.
module capture_frequency_meter #(
  parameter int TIMER_BITS = cfm_pkg::TIMER_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  cfm_in_if.sink           item,
  cfm_out_if.source        result
);

  // The capture field is 16 bits wide; narrower timers mask its upper bits.
  localparam int          MASK_BITS = (TIMER_BITS < cfm_pkg::CAPTURE_BITS) ?
                                      TIMER_BITS : cfm_pkg::CAPTURE_BITS;
  localparam logic [16:0] CAP_LIM   = 17'(1) << MASK_BITS;
  localparam logic [15:0] CAP_MASK  = 16'(CAP_LIM - 17'd1);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_AVG_GO,
    S_AVG_WAIT,
    S_FRQ_GO,
    S_FRQ_WAIT,
    S_EMIT
  } state_t;

  state_t        state;
  logic          armed;
  logic [31:0]   gate_cycles;
  logic [15:0]   overflow_count;
  logic [15:0]   previous_capture;
  logic [31:0]   cycle_sum;
  logic [15:0]   period_count;

  logic [31:0]   avg_r;
  logic [30:0]   scale_r;
  cfm_pkg::unit_t unit_r;
  logic [16:0]   freq_r;

  logic          out_valid;
  logic [31:0]   out_period;
  logic [16:0]   out_freq;
  logic [1:0]    out_unit;
  logic          out_zero;

  logic          accept;
  logic [15:0]   cap;
  logic [31:0]   ovf_shift;
  logic [31:0]   sum_add;
  logic [31:0]   sum_after;
  logic          gate_hit;

  logic          div_start;
  logic [32:0]   div_num;
  logic [31:0]   div_den;
  logic          div_done;
  logic [32:0]   div_quot;
  logic [31:0]   quot_lo;

  // The meter takes requests only while it is not busy finishing a gate.
  assign item.ready = (state == S_ACCUM);
  assign accept     = item.valid && item.ready;

  // One interval: whole timer wraps plus the difference of the captures.
  // The overflow shift drops out entirely for a 32-bit timer.
  always_comb begin
    cap       = item.capture_value & CAP_MASK;
    ovf_shift = 32'(overflow_count) << TIMER_BITS;
    sum_add   = cycle_sum + ovf_shift + 32'(cap) - 32'(previous_capture);
    sum_after = item.capture_overrun ? cycle_sum : sum_add;
    gate_hit  = (sum_after >= gate_cycles);
  end

  // Operands for the shared divider: the first pass divides the cycle sum
  // by the period count, the second divides the chosen scale by the average.
  always_comb begin
    div_start = 1'b0;
    div_num   = 33'({1'b0, cycle_sum}) + 33'(period_count >> 1);
    div_den   = 32'(period_count);
    case (state)
      S_AVG_GO: begin
        div_start = 1'b1;
      end
      S_FRQ_GO: begin
        div_start = 1'b1;
        div_num   = 33'(scale_r) + 33'(avg_r >> 1);
        div_den   = avg_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cfm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign quot_lo = div_quot[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_ACCUM;
      armed            <= 1'b0;
      gate_cycles      <= cfm_pkg::GATE_RESET;
      overflow_count   <= '0;
      previous_capture <= '0;
      cycle_sum        <= '0;
      period_count     <= '0;
      out_valid        <= 1'b0;
      avg_r            <= '0;
      scale_r          <= '0;
      unit_r           <= cfm_pkg::UNIT_MHZ;
      freq_r           <= '0;
      out_period       <= '0;
      out_freq         <= '0;
      out_unit         <= '0;
      out_zero         <= 1'b0;
    end else begin
      if (cfg_we) begin
        gate_cycles <= cfg_wdata;
      end
      // While a result is being loaded, the load below sets out_valid.
      if (out_valid && result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_ACCUM: begin
          if (accept) begin
            case (item.command)
              cfm_pkg::CMD_START: begin
                overflow_count   <= '0;
                previous_capture <= '0;
                cycle_sum        <= '0;
                period_count     <= '0;
                armed            <= 1'b1;
              end
              cfm_pkg::CMD_TICK: begin
                if (armed) begin
                  overflow_count <= overflow_count + 16'd1;
                end
              end
              cfm_pkg::CMD_CAPTURE: begin
                if (armed) begin
                  // An overrun capture adds no interval and no period; it resynchronizes the reference.
                  if (!item.capture_overrun) begin
                    cycle_sum    <= sum_add;
                    period_count <= period_count + 16'd1;
                  end
                  previous_capture <= cap;
                  overflow_count   <= '0;
                  if (gate_hit) begin
                    armed <= 1'b0;
                    state <= S_AVG_GO;
                  end
                end
              end
              default: begin
                armed <= armed;
              end
            endcase
          end
        end
        S_AVG_GO: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            avg_r <= quot_lo;
            if (quot_lo <= cfm_pkg::LIMIT_MHZ) begin
              scale_r <= cfm_pkg::SCALE_MHZ;
              unit_r  <= cfm_pkg::UNIT_MHZ;
            end else if (quot_lo <= cfm_pkg::LIMIT_KHZ) begin
              scale_r <= cfm_pkg::SCALE_KHZ;
              unit_r  <= cfm_pkg::UNIT_KHZ;
            end else begin
              scale_r <= cfm_pkg::SCALE_HZ;
              unit_r  <= cfm_pkg::UNIT_HZ;
            end
            state <= S_FRQ_GO;
          end
        end
        S_FRQ_GO: begin
          state <= S_FRQ_WAIT;
        end
        S_FRQ_WAIT: begin
          if (div_done) begin
            // A zero average gives a zero quotient from the divider.
            freq_r <= div_quot[16:0];
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Wait here only if an earlier result is still held and stalled.
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_period <= avg_r;
            out_freq   <= freq_r;
            out_unit   <= unit_r;
            out_zero   <= (avg_r == '0);
            state      <= S_ACCUM;
          end
        end
        default: begin
          state <= S_ACCUM;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.average_period = out_period;
  assign result.frequency_x100 = out_freq;
  assign result.unit           = out_unit;
  assign result.zero_period    = out_zero;

`ifndef ASSERT_OFF
  // A zero period forces a zero frequency reported in the megahertz unit.
  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero) |-> (out_freq == '0 && out_unit == cfm_pkg::UNIT_MHZ))
    else $error("zero period with nonzero frequency or unit");

  // A megahertz unit is only reported with a period of at most LIMIT_MHZ.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_unit == cfm_pkg::UNIT_MHZ) |-> (out_period <= cfm_pkg::LIMIT_MHZ))
    else $error("megahertz unit with a long period");

  // The meter is disarmed for the whole time it finishes a gate.
  a_disarmed: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACCUM) |-> !armed)
    else $error("meter armed while finishing a gate");

  // A capture that reaches the gate starts the average division next cycle.
  a_gate_start: assert property (@(posedge clk) disable iff (rst)
    (accept && armed && item.command == cfm_pkg::CMD_CAPTURE && gate_hit)
      |=> div_start)
    else $error("gate reached without starting the division");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The timer width the meter is built with, and the one unused command code.
  localparam int          TIMER_WIDTH = 16;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  // Gate length after reset and the period thresholds and scale factors that
  // turn an average period of a 16 MHz clock into a frequency times 100.
  localparam logic [31:0] GATE_AT_RESET   = 32'd32000000;
  localparam logic [63:0] MHZ_PERIOD_MAX  = 64'd16;
  localparam logic [63:0] KHZ_PERIOD_MAX  = 64'd16000;
  localparam logic [63:0] MHZ_SCALE       = 64'd1600;
  localparam logic [63:0] KHZ_SCALE       = 64'd1600000;
  localparam logic [63:0] HZ_SCALE        = 64'd1600000000;

  // Quiet cycles that follow each drain and let the meter settle.
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_REQUESTS = 350;
  localparam int unsigned RANDOM_RESULTS  = 30;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] capture_value;
    logic        capture_overrun;
  } meter_request_t;

  typedef struct packed {
    logic [31:0]    average_period;
    logic [16:0]    frequency_x100;
    cfm_pkg::unit_t unit;
    logic           zero_period;
  } measurement_t;

  // The book follows the meter's counters request by request and keeps the
  // measurements the meter still owes, oldest first.
  class measurement_book;
    logic [31:0]  gate_cycles;
    logic [15:0]  overflow_count;
    logic [15:0]  previous_capture;
    logic [31:0]  cycle_sum;
    logic [15:0]  period_count;
    bit           armed;
    measurement_t owed_measurements[$];
    int unsigned  errors;
    int unsigned  measurements_checked;
    int unsigned  requests_counted;
    int unsigned  unit_hits[3];
    int unsigned  zero_hits;

    function new();
      gate_cycles          = GATE_AT_RESET;
      overflow_count       = '0;
      previous_capture     = '0;
      cycle_sum            = '0;
      period_count         = '0;
      armed                = 1'b0;
      errors               = 0;
      measurements_checked = 0;
      requests_counted     = 0;
      zero_hits            = 0;
      foreach (unit_hits[i]) unit_hits[i] = 0;
    endfunction

    function void set_gate(logic [31:0] value);
      gate_cycles = value;
    endfunction

    function int unsigned owed();
      return owed_measurements.size();
    endfunction

    // Applies one accepted request and, when it closes the gate, records
    // the measurement that the meter has to deliver for it.
    function void apply_request(meter_request_t req);
      logic [63:0]  span;
      logic [63:0]  periods;
      logic [63:0]  average;
      logic [63:0]  scale;
      logic [63:0]  frequency;
      measurement_t result;
      if (req.command == cfm_pkg::CMD_START) begin
        overflow_count   = '0;
        previous_capture = '0;
        cycle_sum        = '0;
        period_count     = '0;
        armed            = 1'b1;
        requests_counted++;
      end else if (armed && req.command == cfm_pkg::CMD_TICK) begin
        overflow_count++;
        requests_counted++;
      end else if (armed && req.command == cfm_pkg::CMD_CAPTURE) begin
        requests_counted++;
        if (!req.capture_overrun) begin
          span = 64'(cycle_sum) + (64'(overflow_count) << TIMER_WIDTH)
               + 64'(req.capture_value) - 64'(previous_capture);
          cycle_sum = span[31:0];
          period_count++;
        end
        previous_capture = req.capture_value;
        overflow_count   = '0;
        if (cycle_sum >= gate_cycles) begin
          armed   = 1'b0;
          periods = 64'(period_count);
          average = (periods == 0) ? 64'd0 : (64'(cycle_sum) + periods / 2) / periods;
          if (average <= MHZ_PERIOD_MAX) begin
            scale       = MHZ_SCALE;
            result.unit = cfm_pkg::UNIT_MHZ;
          end else if (average <= KHZ_PERIOD_MAX) begin
            scale       = KHZ_SCALE;
            result.unit = cfm_pkg::UNIT_KHZ;
          end else begin
            scale       = HZ_SCALE;
            result.unit = cfm_pkg::UNIT_HZ;
          end
          frequency = (average == 0) ? 64'd0 : (scale + average / 2) / average;
          result.average_period = average[31:0];
          result.frequency_x100 = frequency[16:0];
          result.zero_period    = (average == 0);
          owed_measurements.push_back(result);
        end
      end
    endfunction

    function void compare_measurement(measurement_t got);
      measurement_t want;
      if (owed_measurements.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: measurement with none owed: period %0d freq %0d unit %0d zero %0b",
                   got.average_period, got.frequency_x100, got.unit, got.zero_period);
        return;
      end
      want = owed_measurements.pop_front();
      measurements_checked++;
      unit_hits[want.unit]++;
      if (want.zero_period) zero_hits++;
      if (got.average_period !== want.average_period ||
          got.frequency_x100 !== want.frequency_x100 ||
          got.unit !== want.unit || got.zero_period !== want.zero_period) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: measurement %0d expected period %0d freq %0d unit %0d zero %0b",
                   measurements_checked, want.average_period, want.frequency_x100,
                   want.unit, want.zero_period);
          $display("       got period %0d freq %0d unit %0d zero %0b",
                   got.average_period, got.frequency_x100, got.unit, got.zero_period);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  cfm_in_if  item_if ();
  cfm_out_if result_if ();

  capture_frequency_meter #(
    .TIMER_BITS (TIMER_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  measurement_book book;

  // Requests waiting to be offered to the meter. The sequence pushes them and
  // the request source hands them over one handshake at a time; the two
  // counters tell the sequence when every pushed request has been accepted.
  meter_request_t request_q[$];
  int unsigned    requests_queued   = 0;
  int unsigned    requests_accepted = 0;
  int unsigned    gate_writes       = 0;

  // Request source. It works in bursts of random length separated by random
  // gaps, and holds a request steady for as long as the meter is not ready.
  // All of its signals change only with nonblocking assignments at the rising
  // edge, and each of them at most once per edge.
  initial begin : request_source
    meter_request_t on_bus;
    int unsigned    burst_left;
    int unsigned    gap_left;
    item_if.valid           <= 1'b0;
    item_if.command         <= cfm_pkg::CMD_START;
    item_if.capture_value   <= '0;
    item_if.capture_overrun <= 1'b0;
    on_bus     = '0;
    burst_left = 0;
    gap_left   = 0;
    forever begin
      @(posedge clk);
      if (item_if.valid && item_if.ready) begin
        book.apply_request(on_bus);
        requests_accepted++;
      end
      if (rst) begin
        item_if.valid <= 1'b0;
      end else if (!(item_if.valid && !item_if.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_bus = request_q.pop_front();
          item_if.command         <= on_bus.command;
          item_if.capture_value   <= on_bus.capture_value;
          item_if.capture_overrun <= on_bus.capture_overrun;
          item_if.valid           <= 1'b1;
          // At the end of a burst a new one is sized; a quarter of the bursts
          // run straight into the next one with no gap at all.
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink. Readiness follows a 16-bit pattern that is redrawn at the
  // start of every window: sometimes solid, sometimes sparse or dense stalls.
  initial begin : result_sink
    logic [15:0] stall_pattern;
    int unsigned slot;
    result_if.ready <= 1'b0;
    stall_pattern = 16'hFFFF;
    slot          = 0;
    forever begin
      @(posedge clk);
      if (result_if.valid && result_if.ready)
        book.compare_measurement({result_if.average_period, result_if.frequency_x100,
                                  cfm_pkg::unit_t'(result_if.unit),
                                  result_if.zero_period});
      if (slot == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom);
          2:       stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom);
        endcase
      end
      result_if.ready <= stall_pattern[slot];
      slot = (slot + 1) % 16;
    end
  end

  // Any handshake on either channel counts as progress. A long stretch
  // without one means the meter has hung or lost a request.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("ERROR: no request moved for %0d cycles, %0d measurements still owed",
             WATCHDOG_LIMIT, book.owed());
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_request(input logic [1:0] command, input logic [15:0] value,
                              input logic overrun);
    request_q.push_back('{command: command, capture_value: value,
                          capture_overrun: overrun});
    requests_queued++;
  endtask

  // Waits until every pushed request has been accepted and every owed
  // measurement has arrived, then lets the meter settle.
  task automatic drain();
    while (requests_accepted != requests_queued || book.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called only from an idle meter, right after a drain.
  task automatic write_gate(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_gate(value);
    gate_writes++;
  endtask

  // One measurement as a real input would produce it: a free-running timer
  // is followed across a few input periods sized so that the gate closes
  // after about that many captures. Each timer wrap on the way is a tick.
  // With the largest gate only a wrapping sum can close it, so there the
  // content is random.
  task automatic push_measurement(input logic [31:0] gate);
    logic [63:0] target;
    logic [63:0] timer_now;
    logic [63:0] timer_next;
    int unsigned periods;
    periods = $urandom_range(1, 6);
    push_request(cfm_pkg::CMD_START, 16'($urandom), 1'($urandom_range(0, 1)));
    if (gate == 32'hFFFF_FFFF) begin
      repeat (periods + 1) begin
        if ($urandom_range(0, 2) == 0)
          push_request(cfm_pkg::CMD_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
        else
          push_request(cfm_pkg::CMD_CAPTURE, 16'($urandom), $urandom_range(0, 3) == 0);
      end
    end else begin
      target    = 64'(gate) / periods;
      timer_now = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'($urandom_range(0, 65535));
      repeat (periods + 1) begin
        if ($urandom_range(0, 15) == 0)
          timer_next = timer_now;
        else
          timer_next = timer_now + target / 2 + ($urandom % (target + 1));
        repeat (timer_next[63:16] - timer_now[63:16])
          push_request(cfm_pkg::CMD_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
        push_request(cfm_pkg::CMD_CAPTURE, timer_next[15:0], $urandom_range(0, 11) == 0);
        timer_now = timer_next;
      end
    end
  endtask

  // Up to two requests of any kind, the unused command code among the choices.
  task automatic push_noise();
    repeat ($urandom_range(0, 2))
      push_request(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // An overrun capture one count ahead followed by a normal capture makes
  // the sum wrap to all ones, which closes any gate and leaves the meter
  // disarmed before the next gate write.
  task automatic push_closer();
    logic [15:0] resync;
    resync = 16'($urandom_range(0, 65534));
    push_request(cfm_pkg::CMD_START, 16'($urandom), 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, resync + 16'd1, 1'b1);
    push_request(cfm_pkg::CMD_CAPTURE, resync, 1'b0);
  endtask

  initial begin : test_sequence
    int unsigned directed_requests;
    int unsigned directed_results;
    logic [31:0] gate;
    book = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // With the gate still at its reset value: requests to an idle meter and
    // the unused command are ignored, and a few timer spans stay far below
    // the gate. Only a sum that wraps to all ones closes it.
    push_request(cfm_pkg::CMD_TICK, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'hFFFF, 1'b1);
    push_request(CMD_UNUSED, 16'hAAAA, 1'b1);
    push_request(cfm_pkg::CMD_START, 16'h5555, 1'b0);
    repeat (3) push_request(cfm_pkg::CMD_TICK, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'hFFFF, 1'b0);
    push_closer();
    push_request(cfm_pkg::CMD_CAPTURE, 16'd100, 1'b0);
    push_request(cfm_pkg::CMD_TICK, 16'hFFFF, 1'b1);
    drain();

    // The smallest gate: every capture that adds anything closes it, so a
    // single capture sets the average period directly. The captures sit on
    // both sides of each unit threshold and at the top of the timer range.
    write_gate(32'd1);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'h5555, 1'b1);
    push_request(cfm_pkg::CMD_CAPTURE, 16'h5556, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'hFFFF, 1'b1);
    push_request(cfm_pkg::CMD_TICK, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'h0000, 1'b1);
    push_request(cfm_pkg::CMD_CAPTURE, 16'd3, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'd16, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'd17, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'd16000, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'd16001, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'hFFFF, 1'b0);
    push_request(cfm_pkg::CMD_START, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_TICK, 16'h0000, 1'b0);
    push_request(cfm_pkg::CMD_CAPTURE, 16'h0000, 1'b0);
    drain();

    // The largest gate, closed by a sum that wraps to all ones.
    write_gate(32'hFFFF_FFFF);
    push_closer();
    drain();

    // Random part: each phase picks a gate aimed at one unit range (or an
    // extreme), runs several measurements with noise between them and ends
    // with a closing sequence so that the next gate write finds the meter
    // disarmed.
    directed_requests = book.requests_counted;
    directed_results  = book.measurements_checked;
    while (book.requests_counted - directed_requests < RANDOM_REQUESTS ||
           book.measurements_checked - directed_results < RANDOM_RESULTS) begin
      case ($urandom_range(0, 5))
        0:       gate = 32'd1;
        1:       gate = $urandom_range(2, 64);
        2:       gate = $urandom_range(100, 60000);
        3:       gate = $urandom_range(100000, 3000000);
        4:       gate = 32'hFFFF_FFFF;
        default: gate = $urandom_range(16, 128000);
      endcase
      write_gate(gate);
      repeat ($urandom_range(3, 6)) begin
        push_noise();
        push_measurement(gate);
      end
      push_closer();
      drain();
    end

    $display("Covered %0d counted requests under %0d gate settings, %0d measurements checked.",
             book.requests_counted, gate_writes, book.measurements_checked);
    $display("Measurements by unit: %0d MHz, %0d kHz, %0d Hz; %0d with a zero period.",
             book.unit_hits[cfm_pkg::UNIT_MHZ], book.unit_hits[cfm_pkg::UNIT_KHZ],
             book.unit_hits[cfm_pkg::UNIT_HZ], book.zero_hits);
    if (book.errors == 0 && book.owed() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures, %0d measurements still owed", book.errors, book.owed());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cfm_pkg.sv
rtl/core/cfm_if.sv
rtl/core/cfm_div.sv
rtl/core/capture_frequency_meter.sv
verif/tb_top.sv
